>>> hw/rtl/prsd_pkg.sv
// shared types and constants of the palettized run-length sprite decoder
`timescale 1ns / 1ps
package prsd_pkg;

  localparam int MAX_WIDTH       = 4096;
  localparam int PALETTE_ENTRIES = 256;

  localparam int BYTE_W  = 8;
  localparam int LW_W    = 12;
  localparam int SPAN_W  = 12;
  localparam int CNT_W   = 7;
  localparam int COLOR_W = 3 * BYTE_W;
  localparam int PAL_AW  = $clog2(PALETTE_ENTRIES);

  // line column saturates at twice the maximum width minus one
  localparam int COL_W   = $clog2(2 * MAX_WIDTH);
  localparam int SUM_W   = ((COL_W > BYTE_W) ? COL_W : BYTE_W) + 1;
  localparam int CMP_W   = (COL_W > LW_W) ? COL_W : LW_W;
  localparam logic [COL_W-1:0] COL_LIMIT = COL_W'(2 * MAX_WIDTH - 1);

  localparam logic [LW_W-1:0] LINE_WIDTH_RST = LW_W'(320);

  localparam logic [BYTE_W-1:0] KEY_R = 8'd0;
  localparam logic [BYTE_W-1:0] KEY_G = 8'd254;
  localparam logic [BYTE_W-1:0] KEY_B = 8'd0;

  localparam logic OP_PALETTE = 1'b0;
  localparam logic OP_CODE    = 1'b1;

  localparam logic [BYTE_W-1:0] CODE_EOL  = 8'd0;
  localparam logic [BYTE_W-1:0] CODE_SKIP = 8'd1;

  typedef enum logic [3:0] {
    MODE_OPCODE  = 4'b0001,
    MODE_SKIP    = 4'b0010,
    MODE_RUN     = 4'b0100,
    MODE_LITERAL = 4'b1000
  } parse_mode_t;

  // span control carried alongside the palette read
  typedef struct packed {
    logic              valid;
    logic [SPAN_W-1:0] len;
    logic              use_pal;
    logic              eol;
    logic              ovf;
  } span_ctl_t;

  typedef struct packed {
    logic [SPAN_W-1:0] span_length;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
    logic              is_transparent;
    logic              end_of_line;
    logic              line_overflow;
  } span_out_t;

endpackage

>>> hw/rtl/prsd_if.sv
// valid/ready channel interfaces for the decoder input and span output
`timescale 1ns / 1ps
interface prsd_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic       start_of_image;
  logic [7:0] code_byte;
  logic [7:0] palette_index;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;

  modport source (output valid, operation, start_of_image, code_byte, palette_index,
                  red_in, green_in, blue_in, input ready);
  modport sink (input valid, operation, start_of_image, code_byte, palette_index,
                red_in, green_in, blue_in, output ready);
endinterface

interface prsd_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] span_length;
  logic [7:0]  red_out;
  logic [7:0]  green_out;
  logic [7:0]  blue_out;
  logic        is_transparent;
  logic        end_of_line;
  logic        line_overflow;

  modport source (output valid, span_length, red_out, green_out, blue_out,
                  is_transparent, end_of_line, line_overflow, input ready);
  modport sink (input valid, span_length, red_out, green_out, blue_out,
                is_transparent, end_of_line, line_overflow, output ready);
endinterface

>>> hw/rtl/palettized_rle_sprite_decoder.sv
// top level: run-length sprite parser, palette memory and span output register
// a span is registered first with the palette read, then in the output register
// one item per cycle unless the output stalls; ram read and column add set the pace
// palette writes and opcode bytes other than end of line give no span
// reset (synchronous, rst_n low) returns the parser to opcode mode, column and count
// to zero, line width to 320 and empties the pipeline; palette contents are kept
`timescale 1ns / 1ps
module palettized_rle_sprite_decoder (
  input  logic                   clk,
  input  logic                   rst_n,
  prsd_in_if.sink                in_chan,
  prsd_out_if.source             out_chan,
  input  logic                   cfg_we,
  input  logic [prsd_pkg::LW_W-1:0] cfg_wdata
);
  import prsd_pkg::*;

  logic [LW_W-1:0]   line_width_r;
  parse_mode_t       mode_r, mode_nxt, mode_eff;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt, cnt_eff;
  logic [COL_W-1:0]  col_r, col_nxt, col_eff, col_adv;
  logic [SUM_W-1:0]  col_sum;
  logic [BYTE_W-1:0] adv_n;
  logic              adv_ovf, eol_ovf;
  span_ctl_t         s1_r, s1_nxt;
  span_out_t         out_r, out_nxt;
  logic              out_valid_r;
  logic              in_fire, s1_adv, code_fire;
  logic [COLOR_W-1:0] pal_wdata, pal_rdata;
  logic [BYTE_W-1:0] red_s, green_s, blue_s;

  assign s1_adv    = s1_r.valid && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !s1_r.valid || s1_adv;
  assign in_fire   = in_chan.valid && in_chan.ready;
  assign code_fire = in_fire && (in_chan.operation == OP_CODE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_width_r <= LINE_WIDTH_RST;
    end else if (cfg_we) begin
      line_width_r <= cfg_wdata;
    end
  end

  // start of image restarts the parser before this byte is handled
  assign mode_eff = in_chan.start_of_image ? MODE_OPCODE : mode_r;
  assign cnt_eff  = in_chan.start_of_image ? '0 : cnt_r;
  assign col_eff  = in_chan.start_of_image ? '0 : col_r;

  always_comb begin
    unique case (mode_eff)
      MODE_SKIP:    adv_n = in_chan.code_byte;
      MODE_RUN:     adv_n = BYTE_W'(cnt_eff);
      MODE_LITERAL: adv_n = BYTE_W'(1);
      default:      adv_n = '0;
    endcase
  end

  assign col_sum = SUM_W'(col_eff) + SUM_W'(adv_n);
  assign col_adv = (col_sum > SUM_W'(COL_LIMIT)) ? COL_LIMIT : COL_W'(col_sum);
  assign adv_ovf = CMP_W'(col_adv) > CMP_W'(line_width_r);
  assign eol_ovf = CMP_W'(col_eff) > CMP_W'(line_width_r);

  always_comb begin
    mode_nxt       = mode_eff;
    cnt_nxt        = cnt_eff;
    col_nxt        = col_eff;
    s1_nxt.valid   = 1'b0;
    s1_nxt.len     = SPAN_W'(adv_n);
    s1_nxt.use_pal = 1'b0;
    s1_nxt.eol     = 1'b0;
    s1_nxt.ovf     = adv_ovf;
    unique case (mode_eff)
      MODE_SKIP: begin
        mode_nxt     = MODE_OPCODE;
        col_nxt      = col_adv;
        s1_nxt.valid = 1'b1;
      end
      MODE_RUN: begin
        mode_nxt       = MODE_OPCODE;
        cnt_nxt        = '0;
        col_nxt        = col_adv;
        s1_nxt.valid   = 1'b1;
        s1_nxt.use_pal = 1'b1;
      end
      MODE_LITERAL: begin
        cnt_nxt        = cnt_eff - CNT_W'(1);
        col_nxt        = col_adv;
        s1_nxt.valid   = 1'b1;
        s1_nxt.use_pal = 1'b1;
        if (cnt_eff == CNT_W'(1)) begin
          mode_nxt = MODE_OPCODE;
        end
      end
      default: begin
        priority if (in_chan.code_byte == CODE_EOL) begin
          col_nxt      = '0;
          s1_nxt.valid = 1'b1;
          s1_nxt.eol   = 1'b1;
          s1_nxt.ovf   = eol_ovf;
          s1_nxt.len   = eol_ovf ? '0
                         : SPAN_W'(CMP_W'(line_width_r) - CMP_W'(col_eff));
        end else if (in_chan.code_byte == CODE_SKIP) begin
          mode_nxt = MODE_SKIP;
        end else if (!in_chan.code_byte[0]) begin
          cnt_nxt  = in_chan.code_byte[BYTE_W-1:1];
          mode_nxt = MODE_RUN;
        end else begin
          cnt_nxt  = in_chan.code_byte[BYTE_W-1:1];
          mode_nxt = MODE_LITERAL;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_OPCODE;
      cnt_r  <= '0;
      col_r  <= '0;
    end else if (code_fire) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
      col_r  <= col_nxt;
    end
  end

  // components are stored times four
  assign pal_wdata = {in_chan.red_in[BYTE_W-3:0], 2'b00,
                      in_chan.green_in[BYTE_W-3:0], 2'b00,
                      in_chan.blue_in[BYTE_W-3:0], 2'b00};

  // a write lands at an earlier edge than any later read, so no forwarding is needed
  prsd_ram #(
    .WIDTH (COLOR_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk   (clk),
    .we    (in_fire && (in_chan.operation == OP_PALETTE)),
    .waddr (in_chan.palette_index[PAL_AW-1:0]),
    .wdata (pal_wdata),
    .re    (in_fire),
    .raddr (in_chan.code_byte[PAL_AW-1:0]),
    .rdata (pal_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r.valid <= 1'b0;
    end else if (in_fire) begin
      s1_r.valid <= code_fire && s1_nxt.valid;
    end else if (s1_adv) begin
      s1_r.valid <= 1'b0;
    end
    if (in_fire) begin
      s1_r.len     <= s1_nxt.len;
      s1_r.use_pal <= s1_nxt.use_pal;
      s1_r.eol     <= s1_nxt.eol;
      s1_r.ovf     <= s1_nxt.ovf;
    end
  end

  always_comb begin
    red_s   = s1_r.use_pal ? pal_rdata[3*BYTE_W-1:2*BYTE_W] : KEY_R;
    green_s = s1_r.use_pal ? pal_rdata[2*BYTE_W-1:BYTE_W]   : KEY_G;
    blue_s  = s1_r.use_pal ? pal_rdata[BYTE_W-1:0]          : KEY_B;
    out_nxt.span_length    = s1_r.len;
    out_nxt.red            = red_s;
    out_nxt.green          = green_s;
    out_nxt.blue           = blue_s;
    out_nxt.is_transparent = (red_s == KEY_R) && (green_s == KEY_G) && (blue_s == KEY_B);
    out_nxt.end_of_line    = s1_r.eol;
    out_nxt.line_overflow  = s1_r.ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_chan.valid          = out_valid_r;
  assign out_chan.span_length    = out_r.span_length;
  assign out_chan.red_out        = out_r.red;
  assign out_chan.green_out      = out_r.green;
  assign out_chan.blue_out       = out_r.blue;
  assign out_chan.is_transparent = out_r.is_transparent;
  assign out_chan.end_of_line    = out_r.end_of_line;
  assign out_chan.line_overflow  = out_r.line_overflow;

endmodule

>>> hw/rtl/prsd_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module prsd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> hw/rtl/prsd_checker.sv
// port-level checks of the sprite decoder, bound to the top level
`timescale 1ns / 1ps
module prsd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [11:0] span_length,
  input logic [7:0]  red_out,
  input logic [7:0]  green_out,
  input logic [7:0]  blue_out,
  input logic        is_transparent,
  input logic        end_of_line,
  input logic        line_overflow
);
  import prsd_pkg::*;

  // a stalled span keeps valid
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("span dropped while stalled");

  // a stalled span keeps its length, red component, end-of-line and overflow flags
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(span_length) && $stable(red_out)
      && $stable(end_of_line) && $stable(line_overflow))
    else $error("span payload changed while stalled");

  // reset empties the output register
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("span shown right after reset");

  // padding spans are always the transparent key
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && end_of_line |-> is_transparent && red_out == KEY_R
      && green_out == KEY_G && blue_out == KEY_B)
    else $error("padding span not transparent");

  // an overflowed line closes with zero padding
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && end_of_line && line_overflow |-> span_length == '0)
    else $error("overflowed line padded");

endmodule

bind palettized_rle_sprite_decoder prsd_checker u_prsd_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_chan.valid),
  .out_ready      (out_chan.ready),
  .span_length    (out_chan.span_length),
  .red_out        (out_chan.red_out),
  .green_out      (out_chan.green_out),
  .blue_out       (out_chan.blue_out),
  .is_transparent (out_chan.is_transparent),
  .end_of_line    (out_chan.end_of_line),
  .line_overflow  (out_chan.line_overflow)
);
